### rtl/rcfp_pkg.sv
// Shared types and constants for the RC channel frame parser.
// Used by rcfp_parse, rc_channel_frame_parser and rcfp_checker; depends on nothing.

package rcfp_pkg;

  localparam logic [7:0] HDR_DOLLAR      = 8'h24;
  localparam logic [7:0] HDR_R           = 8'h52;
  localparam logic [7:0] HDR_C           = 8'h43;
  localparam logic [7:0] LAST_CONTROL_CH = 8'd3;
  localparam logic [7:0] FIRST_CH        = 8'd0;

  // Index of the next expected frame byte, one-hot.
  typedef enum logic [6:0] {
    POS_DOLLAR = 7'b0000001,
    POS_R      = 7'b0000010,
    POS_C      = 7'b0000100,
    POS_CHAN   = 7'b0001000,
    POS_LOW    = 7'b0010000,
    POS_HIGH   = 7'b0100000,
    POS_CSUM   = 7'b1000000
  } pos_t;

  typedef struct packed {
    logic [7:0]  channel;
    logic [15:0] value;
    logic        is_control;
    logic        group_done;
    logic        group_start;
  } result_t;

endpackage

### rtl/rc_channel_frame_parser.sv
// Top level of the RC channel frame parser: parse core plus output register and skid stage.
// Depends on rcfp_pkg and rcfp_parse.
//
//   channel   | direction | payload                                          | handshake
//   in_       | input     | data_byte[7:0]                                   | in_valid / in_stall
//   out_      | output    | channel[7:0] value[15:0] is_control group_done group_start | out_valid / out_stall
//
// One byte is taken per cycle while in_stall is low, and the parse state updates once per taken byte;
// a result (checksum match) is registered into the output register, or into the skid stage while stalled.
// Reset (rst_n low at a clock edge) returns to awaiting '$' and empties both output slots.
// While out_stall holds, a second result waits in the skid stage; in_stall rises only when
// that skid stage is full.

module rc_channel_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_channel,
  output logic [15:0] out_value,
  output logic        out_is_control,
  output logic        out_group_done,
  output logic        out_group_start
);

  logic              in_acc;
  logic              res_vld;
  rcfp_pkg::result_t res;

  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  rcfp_pkg::result_t out_data_r, out_data_nxt;
  rcfp_pkg::result_t skid_data_r, skid_data_nxt;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;

  rcfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (in_acc),
    .data_byte (in_data_byte),
    .res_vld   (res_vld),
    .res       (res)
  );

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (!out_vld_r || !out_stall) begin
      // output slot frees: drain skid first, else take the new result
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = res_vld;
        out_data_nxt = res;
      end
    end else if (res_vld) begin
      // output held: park the new result in the skid stage
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_channel     = out_data_r.channel;
  assign out_value       = out_data_r.value;
  assign out_is_control  = out_data_r.is_control;
  assign out_group_done  = out_data_r.group_done;
  assign out_group_start = out_data_r.group_start;

endmodule

### rtl/rcfp_parse.sv
// Frame parse state and result decode for the RC channel frame parser.
// Depends on rcfp_pkg.

module rcfp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          data_byte,
  output logic                res_vld,
  output rcfp_pkg::result_t   res
);

  rcfp_pkg::pos_t pos_r, pos_nxt;
  logic [7:0]     xor_r, xor_nxt;
  logic [7:0]     chan_r, chan_nxt;
  logic [15:0]    value_r, value_nxt;

  always_comb begin
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    chan_nxt  = chan_r;
    value_nxt = value_r;
    res_vld   = 1'b0;
    unique case (pos_r)
      rcfp_pkg::POS_R: begin
        if (data_byte == rcfp_pkg::HDR_R) begin
          xor_nxt = xor_r ^ data_byte;
          pos_nxt = rcfp_pkg::POS_C;
        end else begin
          xor_nxt = 8'h00;
          pos_nxt = rcfp_pkg::POS_DOLLAR;
        end
      end
      rcfp_pkg::POS_C: begin
        if (data_byte == rcfp_pkg::HDR_C) begin
          xor_nxt = xor_r ^ data_byte;
          pos_nxt = rcfp_pkg::POS_CHAN;
        end else begin
          xor_nxt = 8'h00;
          pos_nxt = rcfp_pkg::POS_DOLLAR;
        end
      end
      rcfp_pkg::POS_CHAN: begin
        chan_nxt = data_byte;
        xor_nxt  = xor_r ^ data_byte;
        pos_nxt  = rcfp_pkg::POS_LOW;
      end
      rcfp_pkg::POS_LOW: begin
        value_nxt = {8'h00, data_byte};
        xor_nxt   = xor_r ^ data_byte;
        pos_nxt   = rcfp_pkg::POS_HIGH;
      end
      rcfp_pkg::POS_HIGH: begin
        value_nxt = {data_byte, value_r[7:0]};
        xor_nxt   = xor_r ^ data_byte;
        pos_nxt   = rcfp_pkg::POS_CSUM;
      end
      rcfp_pkg::POS_CSUM: begin
        // emit only on a matching checksum, restart either way
        res_vld = byte_vld && (xor_r == data_byte);
        xor_nxt = 8'h00;
        pos_nxt = rcfp_pkg::POS_DOLLAR;
      end
      default: begin
        // awaiting '$'; a mismatching byte is dropped
        if (data_byte == rcfp_pkg::HDR_DOLLAR) begin
          value_nxt = 16'h0000;
          xor_nxt   = rcfp_pkg::HDR_DOLLAR;
          pos_nxt   = rcfp_pkg::POS_R;
        end else begin
          xor_nxt = 8'h00;
          pos_nxt = rcfp_pkg::POS_DOLLAR;
        end
      end
    endcase
  end

  always_comb begin
    res.channel     = chan_r;
    res.value       = value_r;
    res.is_control  = (chan_r <= rcfp_pkg::LAST_CONTROL_CH);
    res.group_done  = (chan_r == rcfp_pkg::LAST_CONTROL_CH);
    res.group_start = (chan_r == rcfp_pkg::FIRST_CH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= rcfp_pkg::POS_DOLLAR;
      xor_r <= 8'h00;
    end else if (byte_vld) begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
    end
  end

  // held channel and value are always written before a result uses them
  always_ff @(posedge clk) begin
    if (byte_vld) begin
      chan_r  <= chan_nxt;
      value_r <= value_nxt;
    end
  end

endmodule

### rtl/rcfp_checker.sv
// Port-level checks for rc_channel_frame_parser, attached by the bind below.
// Depends on rcfp_pkg for the control channel limit and the first channel.

module rcfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_channel,
  input logic [15:0] out_value,
  input logic        out_is_control,
  input logic        out_group_done,
  input logic        out_group_start
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_channel) && $stable(out_value))
    else $error("stalled result changed");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_control == (out_channel <= rcfp_pkg::LAST_CONTROL_CH)) &&
                  (out_group_done == (out_channel == rcfp_pkg::LAST_CONTROL_CH)) &&
                  (out_group_start == (out_channel == rcfp_pkg::FIRST_CH)))
    else $error("grouping flags disagree with channel");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

endmodule

bind rc_channel_frame_parser rcfp_checker u_rcfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_channel     (out_channel),
  .out_value       (out_value),
  .out_is_control  (out_is_control),
  .out_group_done  (out_group_done),
  .out_group_start (out_group_start)
);
